// ===== hw/rtl/mwml_pkg.sv =====
package mwml_pkg;

	localparam int unsigned NUM_W = 62;
	localparam int unsigned DEN_W = 32;
	localparam int unsigned QUO_W = 31;

	localparam logic [31:0] FRONT_W_RST = 32'hFFFF_D1EC;
	localparam logic [31:0] REAR_W_RST  = 32'hFFFF_C7AE;
	localparam logic [30:0] LIMIT_RST   = 31'h0004_0000;

	typedef enum logic [1:0] {
		REG_FRONT_W,
		REG_REAR_W,
		REG_LIMIT
	} reg_idx_t;

	typedef logic [3:0][31:0] wheel_vec_t;
	typedef logic [3:0][15:0] cur_vec_t;

	typedef struct packed {
		wheel_vec_t w;
		cur_vec_t   cur;
		logic [3:0] neg;
		logic       scaled;
	} side_t;

	typedef struct packed {
		wheel_vec_t w;
		cur_vec_t   cur;
		logic       scaled;
	} res_t;

endpackage

// ===== hw/rtl/mwml_if.sv =====
interface mwml_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] forward_speed;
	logic signed [31:0] sideways_speed;
	logic signed [31:0] turn_rate;
	logic               raw_mode;

	modport source (output valid, forward_speed, sideways_speed, turn_rate, raw_mode,
		input ready);
	modport sink (input valid, forward_speed, sideways_speed, turn_rate, raw_mode,
		output ready);
endinterface

interface mwml_wheel_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] wheel_speed_0;
	logic signed [31:0] wheel_speed_1;
	logic signed [31:0] wheel_speed_2;
	logic signed [31:0] wheel_speed_3;
	logic signed [15:0] raw_current_0;
	logic signed [15:0] raw_current_1;
	logic signed [15:0] raw_current_2;
	logic signed [15:0] raw_current_3;
	logic               was_scaled;

	modport source (output valid, wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3,
		raw_current_0, raw_current_1, raw_current_2, raw_current_3, was_scaled,
		input ready);
	modport sink (input valid, wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3,
		raw_current_0, raw_current_1, raw_current_2, raw_current_3, was_scaled,
		output ready);
endinterface

// ===== hw/rtl/mecanum_wheel_mix_limit.sv =====
// Mecanum wheel mixer with proportional speed limiting.
// Commands enter on cmd (forward, sideways, turn in signed fixed point with
// FRAC_BITS fraction bits, plus raw_mode). Each command yields one word on
// wheel: four wheel speeds, four raw currents and the was_scaled flag.
// A word moves when valid and ready are both high on a rising clock edge.
// The rotation weights and speed limit are written over APB, by the user only while the
// block is idle (the block does not enforce this); a read returns the stored value.
// From cmd acceptance to the word on wheel, a command passes through six
// arithmetic stages, a 31-stage restoring divider (one quotient bit per
// stage) and the output stage. One command is accepted every cycle while
// the skid register is empty. When the receiver stalls, the word in the output
// stage is parked in a skid register and the whole pipeline holds on the next
// cycle; cmd.ready is registered and drops for as long as the skid register
// is full. Nothing is lost or repeated.
// Reset clears all valid bits and the skid flag and loads the register
// reset values; no clearing pass is needed.
module mecanum_wheel_mix_limit import mwml_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	mwml_cmd_if.sink    cmd,
	mwml_wheel_if.source wheel
);

	localparam int unsigned TW = 64 - FRAC_BITS;
	localparam int unsigned SW = TW + 1;

	// configuration registers
	logic [31:0] front_w_q;
	logic [31:0] rear_w_q;
	logic [30:0] limit_q;
	reg_idx_t    reg_idx;

	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_w_q <= FRONT_W_RST;
			rear_w_q  <= REAR_W_RST;
			limit_q   <= LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_FRONT_W: front_w_q <= pwdata;
				REG_REAR_W:  rear_w_q  <= pwdata;
				REG_LIMIT:   limit_q   <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FRONT_W: prdata = front_w_q;
			REG_REAR_W:  prdata = rear_w_q;
			REG_LIMIT:   prdata = {1'b0, limit_q};
			default:     prdata = '0;
		endcase
	end

	// pipeline control
	logic skid_full_q;
	logic en;

	assign en        = !skid_full_q;
	assign cmd.ready = en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_d [1:QUO_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int k = 1; k <= QUO_W; k++) v_d[k] <= 1'b0;
		end else if (en) begin
			v_s1 <= cmd.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_d[1] <= v_s6;
			for (int k = 2; k <= QUO_W; k++) v_d[k] <= v_d[k-1];
			v_s7 <= v_d[QUO_W];
		end
	end

	// stage 1: rotation products and forward/sideways combinations
	logic signed [31:0] fw_sgn, rw_sgn;
	logic signed [63:0] prod_f, prod_r;
	logic signed [63:0] prod_f_s1, prod_r_s1;
	logic [32:0]        sum_s1, dif_s1;
	logic               raw_s1;

	assign fw_sgn = $signed(front_w_q);
	assign rw_sgn = $signed(rear_w_q);
	assign prod_f = fw_sgn * cmd.turn_rate;
	assign prod_r = rw_sgn * cmd.turn_rate;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_f_s1 <= prod_f;
			prod_r_s1 <= prod_r;
			sum_s1    <= {cmd.forward_speed[31], cmd.forward_speed}
				+ {cmd.sideways_speed[31], cmd.sideways_speed};
			dif_s1    <= {cmd.forward_speed[31], cmd.forward_speed}
				- {cmd.sideways_speed[31], cmd.sideways_speed};
			raw_s1    <= cmd.raw_mode;
		end
	end

	// stage 2: divide products by 2^FRAC_BITS toward zero
	logic [63:0]   fr_sum, rr_sum;
	logic [TW-1:0] ft_s2, rt_s2;
	logic [32:0]   sum_s2, dif_s2;
	logic          raw_s2;

	assign fr_sum = prod_f_s1 + {{TW{1'b0}}, {FRAC_BITS{prod_f_s1[63]}}};
	assign rr_sum = prod_r_s1 + {{TW{1'b0}}, {FRAC_BITS{prod_r_s1[63]}}};

	always_ff @(posedge clk) begin
		if (en) begin
			ft_s2  <= fr_sum[63:FRAC_BITS];
			rt_s2  <= rr_sum[63:FRAC_BITS];
			sum_s2 <= sum_s1;
			dif_s2 <= dif_s1;
			raw_s2 <= raw_s1;
		end
	end

	// stage 3: wheel mix, saturated to 32 bits
	function automatic logic [31:0] sat32(input logic [SW-1:0] v);
		logic [31:0] r;
		if (&v[SW-1:31] || ~|v[SW-1:31]) r = v[31:0];
		else r = v[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return r;
	endfunction

	logic [SW-1:0] ft_x, rt_x, sum_x, dif_x;
	wheel_vec_t    w_s3;
	logic          raw_s3;

	assign ft_x  = {ft_s2[TW-1], ft_s2};
	assign rt_x  = {rt_s2[TW-1], rt_s2};
	assign sum_x = {{(SW-33){sum_s2[32]}}, sum_s2};
	assign dif_x = {{(SW-33){dif_s2[32]}}, dif_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			w_s3[0] <= sat32(ft_x - sum_x);
			w_s3[1] <= sat32(ft_x + dif_x);
			w_s3[2] <= sat32(rt_x + sum_x);
			w_s3[3] <= sat32(rt_x - dif_x);
			raw_s3  <= raw_s2;
		end
	end

	// stage 4: magnitudes and raw currents
	wheel_vec_t abs_c;
	cur_vec_t   cur_c;
	logic [32:0] tr [4];
	logic [32:0] qx [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			abs_c[i] = w_s3[i][31] ? (~w_s3[i] + 32'd1) : w_s3[i];
			tr[i] = {w_s3[i][31], w_s3[i]}
				+ {{(33-FRAC_BITS){1'b0}}, {FRAC_BITS{w_s3[i][31]}}};
			qx[i] = {{FRAC_BITS{tr[i][32]}}, tr[i][32:FRAC_BITS]};
			if (!raw_s3) cur_c[i] = '0;
			else if (&qx[i][32:15] || ~|qx[i][32:15]) cur_c[i] = qx[i][15:0];
			else cur_c[i] = qx[i][32] ? 16'h8000 : 16'h7FFF;
		end
	end

	wheel_vec_t w_s4, abs_s4;
	cur_vec_t   cur_s4;
	logic       raw_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			w_s4   <= w_s3;
			abs_s4 <= abs_c;
			cur_s4 <= cur_c;
			raw_s4 <= raw_s3;
		end
	end

	// stage 5: |w| * limit and pairwise maxima
	logic [62:0]      prod_l [4];
	logic [NUM_W-1:0] num_s5 [4];
	logic [31:0]      m01_s5, m23_s5;
	wheel_vec_t       w_s5;
	cur_vec_t         cur_s5;
	logic             raw_s5;

	always_comb begin
		for (int i = 0; i < 4; i++) prod_l[i] = abs_s4[i] * limit_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) num_s5[i] <= prod_l[i][NUM_W-1:0];
			m01_s5 <= (abs_s4[0] > abs_s4[1]) ? abs_s4[0] : abs_s4[1];
			m23_s5 <= (abs_s4[2] > abs_s4[3]) ? abs_s4[2] : abs_s4[3];
			w_s5   <= w_s4;
			cur_s5 <= cur_s4;
			raw_s5 <= raw_s4;
		end
	end

	// stage 6: peak and limit check
	logic [NUM_W-1:0] num_s6 [4];
	logic [31:0]      peak_s6;
	side_t            side_s6;
	logic [31:0]      peak_c;

	assign peak_c = (m01_s5 > m23_s5) ? m01_s5 : m23_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s6         <= num_s5;
			peak_s6        <= peak_c;
			side_s6.w      <= w_s5;
			side_s6.cur    <= cur_s5;
			for (int i = 0; i < 4; i++) side_s6.neg[i] <= w_s5[i][31];
			side_s6.scaled <= !raw_s5 && (peak_c > {1'b0, limit_q});
		end
	end

	// divider lanes and matching delay line
	logic [QUO_W-1:0] quo [4];
	side_t            side_d [1:QUO_W];

	for (genvar i = 0; i < 4; i++) begin : g_div
		mwml_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s6[i]),
			.den (peak_s6),
			.quo (quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[1] <= side_s6;
			for (int k = 2; k <= QUO_W; k++) side_d[k] <= side_d[k-1];
		end
	end

	// stage 7: apply sign and select scaled or plain speeds
	res_t  res_c, res_s7, skid_q, res_out;
	side_t side_e;

	assign side_e = side_d[QUO_W];

	always_comb begin
		res_c.cur    = side_e.cur;
		res_c.scaled = side_e.scaled;
		for (int i = 0; i < 4; i++) begin
			if (!side_e.scaled) res_c.w[i] = side_e.w[i];
			else if (side_e.neg[i]) res_c.w[i] = 32'd0 - {1'b0, quo[i]};
			else res_c.w[i] = {1'b0, quo[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) res_s7 <= res_c;
	end

	// output skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (wheel.ready) skid_full_q <= 1'b0;
		end else if (v_s7 && !wheel.ready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) skid_q <= res_s7;
	end

	assign res_out       = skid_full_q ? skid_q : res_s7;
	assign wheel.valid   = skid_full_q || v_s7;
	assign wheel.wheel_speed_0 = res_out.w[0];
	assign wheel.wheel_speed_1 = res_out.w[1];
	assign wheel.wheel_speed_2 = res_out.w[2];
	assign wheel.wheel_speed_3 = res_out.w[3];
	assign wheel.raw_current_0 = res_out.cur[0];
	assign wheel.raw_current_1 = res_out.cur[1];
	assign wheel.raw_current_2 = res_out.cur[2];
	assign wheel.raw_current_3 = res_out.cur[3];
	assign wheel.was_scaled    = res_out.scaled;

endmodule

// ===== hw/rtl/mwml_div.sv =====
module mwml_div import mwml_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s  [1:QUO_W];
	logic [QUO_W-1:0] bits_s [1:QUO_W];
	logic [DEN_W-1:0] den_s  [1:QUO_W];

	for (genvar k = 1; k <= QUO_W; k++) begin : g_step
		logic [DEN_W-1:0] rem_p;
		logic [QUO_W-1:0] bits_p;
		logic [DEN_W-1:0] den_p;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (k == 1) begin : g_first
			// high part of the numerator is already below the divisor
			assign rem_p  = DEN_W'(num[NUM_W-1:QUO_W]);
			assign bits_p = num[QUO_W-1:0];
			assign den_p  = den;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign bits_p = bits_s[k-1];
			assign den_p  = den_s[k-1];
		end

		assign trial = {rem_p, bits_p[QUO_W-1]};
		assign ge    = (trial >= {1'b0, den_p});

		// quotient bits shift in as numerator bits shift out
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DEN_W'(trial - {1'b0, den_p}) : trial[DEN_W-1:0];
				bits_s[k] <= {bits_p[QUO_W-2:0], ge};
				den_s[k]  <= den_p;
			end
		end
	end

	assign quo = bits_s[QUO_W];

endmodule
